@@ hw/rtl/wpms_pkg.sv @@
package wpms_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_WINDOW_DEF = 4;
    localparam int PIXEL_BITS_DEF = 16;

    // Fixed field and register widths.
    localparam int OUT_BITS      = 20;
    localparam int ROW_BITS      = 12;
    localparam int HEIGHT_BITS   = 13;
    localparam int MAX_HEIGHT    = 4096;
    localparam int WS_BITS       = 3;
    localparam int IW_BITS       = 7;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 13;

    // Register reset values.
    localparam int WINDOW_SIZE_RST  = 2;
    localparam int IMAGE_WIDTH_RST  = 64;
    localparam int IMAGE_HEIGHT_RST = 64;

    // Queue depths between the parts and towards the consumer.
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW_SIZE  = 3'd0,
        CFG_IMAGE_WIDTH  = 3'd1,
        CFG_IMAGE_HEIGHT = 3'd2,
        CFG_POOL_MODE    = 3'd3
    } t_cfg_idx;

    typedef enum logic {
        POOL_MAX = 1'b0,
        POOL_SUM = 1'b1
    } t_pool_mode;

    // Classification of one pixel, made by the front part.
    typedef struct packed {
        logic first;    // first pixel of its window
        logic padded;   // window reaches past the right or bottom edge
        logic emit;     // last real pixel of its window
        logic is_last;  // last pixel of the image
    } t_job_ctrl;

endpackage

@@ hw/rtl/wpms_queue.sv @@
module wpms_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [LW-1:0]    r_level, n_level;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_level == LW'(DEPTH));
    assign o_empty = (r_level == '0);
    assign o_level = r_level;
    assign o_data  = r_mem[r_rptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Pointer and fill level update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_level = r_level;
        if (push_ok) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop_ok) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_level = r_level + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_level <= n_level;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Taking the only beat without a new one leaves the queue empty.
    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && !push_ok && r_level == LW'(1)) |=> o_empty)
        else $error("queue not empty after draining its only beat");

endmodule

@@ hw/rtl/wpms_ram.sv @@
module wpms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; a read in the cycle of a
    // write to the same address returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/wpms_front.sv @@
module wpms_front #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_WINDOW = 4,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_restart,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]            i_win,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]             i_width,
    input  logic [wpms_pkg::HEIGHT_BITS-1:0]           i_height,
    input  logic                                       i_accept,
    input  logic signed [PIXEL_BITS-1:0]               i_pixel,
    output logic                                       o_valid,
    output logic signed [PIXEL_BITS-1:0]               o_pixel,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] o_idx,
    output wpms_pkg::t_job_ctrl                        o_ctrl
);

    import wpms_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int W1 = $clog2(MAX_WIDTH + 1);
    localparam int XW = ((W1 > WW) ? W1 : WW) + 1;
    localparam int YW = HEIGHT_BITS + 1;

    logic [CW-1:0]       r_col_pos, n_col_pos;
    logic [CW-1:0]       r_col_idx, n_col_idx;
    logic [PW-1:0]       r_col_phase, n_col_phase;
    logic [ROW_BITS-1:0] r_row_pos, n_row_pos;
    logic [PW-1:0]       r_row_phase, n_row_phase;

    logic [XW-1:0] x_c, x_c0, x_w, x_wid, x_last_c;
    logic [YW-1:0] y_r, y_r0, y_w, y_hgt, y_last_r;
    logic          pad_c, pad_r;
    logic          col_end, row_end;
    logic          cph_wrap, rph_wrap;

    // Window origin, padding and end-of-window tests for the current pixel.
    always_comb begin
        x_c      = XW'(r_col_pos);
        x_c0     = x_c - XW'(r_col_phase);
        x_w      = XW'(i_win);
        x_wid    = XW'(i_width);
        pad_c    = (x_c0 + x_w) > x_wid;
        x_last_c = pad_c ? x_wid - 1'b1 : x_c0 + x_w - 1'b1;

        y_r      = YW'(r_row_pos);
        y_r0     = y_r - YW'(r_row_phase);
        y_w      = YW'(i_win);
        y_hgt    = YW'(i_height);
        pad_r    = (y_r0 + y_w) > y_hgt;
        y_last_r = pad_r ? y_hgt - 1'b1 : y_r0 + y_w - 1'b1;

        col_end  = (x_c + 1'b1) >= x_wid;
        row_end  = (y_r + 1'b1) >= y_hgt;
        cph_wrap = (XW'(r_col_phase) + 1'b1) >= x_w;
        rph_wrap = (XW'(r_row_phase) + 1'b1) >= x_w;
    end

    // Classification handed to the back part with the pixel.
    always_comb begin
        o_valid        = i_accept;
        o_pixel        = i_pixel;
        o_idx          = r_col_idx;
        o_ctrl.first   = (r_col_phase == '0) && (r_row_phase == '0);
        o_ctrl.padded  = pad_c || pad_r;
        o_ctrl.emit    = (x_c == x_last_c) && (y_r == y_last_r);
        o_ctrl.is_last = (x_c == x_wid - 1'b1) && (y_r == y_hgt - 1'b1);
    end

    // Raster position after the current pixel.
    always_comb begin
        n_col_pos   = r_col_pos;
        n_col_idx   = r_col_idx;
        n_col_phase = r_col_phase;
        n_row_pos   = r_row_pos;
        n_row_phase = r_row_phase;
        if (col_end) begin
            n_col_pos   = '0;
            n_col_idx   = '0;
            n_col_phase = '0;
            if (row_end) begin
                n_row_pos   = '0;
                n_row_phase = '0;
            end else begin
                n_row_pos   = r_row_pos + 1'b1;
                n_row_phase = rph_wrap ? '0 : r_row_phase + 1'b1;
            end
        end else begin
            n_col_pos   = r_col_pos + 1'b1;
            n_col_phase = cph_wrap ? '0 : r_col_phase + 1'b1;
            n_col_idx   = cph_wrap ? r_col_idx + 1'b1 : r_col_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos   <= '0;
            r_col_idx   <= '0;
            r_col_phase <= '0;
            r_row_pos   <= '0;
            r_row_phase <= '0;
        end else if (i_restart) begin
            r_col_pos   <= '0;
            r_col_idx   <= '0;
            r_col_phase <= '0;
            r_row_pos   <= '0;
            r_row_phase <= '0;
        end else if (i_accept) begin
            r_col_pos   <= n_col_pos;
            r_col_idx   <= n_col_idx;
            r_col_phase <= n_col_phase;
            r_row_pos   <= n_row_pos;
            r_row_phase <= n_row_phase;
        end
    end

    // The position inside the window stays below the window side.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (XW'(r_col_phase) < x_w) && (XW'(r_row_phase) < x_w))
        else $error("window phase out of range");

    // The last pixel of the image always closes a window.
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ctrl.is_last) |-> o_ctrl.emit)
        else $error("last pixel of the image does not close a window");

endmodule

@@ hw/rtl/wpms_back.sv @@
module wpms_back #(
    parameter int MAX_WIDTH  = 64,
    parameter int PIXEL_BITS = 16,
    parameter int OUT_DEPTH  = 4
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  wpms_pkg::t_pool_mode                       i_pool_mode,
    input  logic                                       i_job_empty,
    output logic                                       o_job_pop,
    input  logic signed [PIXEL_BITS-1:0]               i_pixel,
    input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] i_idx,
    input  wpms_pkg::t_job_ctrl                        i_ctrl,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]             i_out_level,
    output logic                                       o_res_valid,
    output logic [wpms_pkg::OUT_BITS-1:0]              o_res_pooled,
    output logic                                       o_res_last
);

    import wpms_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW    = $clog2(OUT_DEPTH + 1);
    localparam int ACC_W = (PIXEL_BITS > OUT_BITS) ? PIXEL_BITS : OUT_BITS;
    localparam int SW    = ACC_W + 1;
    localparam logic signed [SW-1:0] SUM_MAX = SW'((1 << (OUT_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] SUM_MIN = SW'(-(1 << (OUT_BITS - 1)));

    // Execute stage: one pixel a cycle while the result queue has room, read-modify-write of its column.
    logic                         r_e_vld;
    logic signed [PIXEL_BITS-1:0] r_e_pix;
    logic [CW-1:0]                r_e_idx;
    t_job_ctrl                    r_e_ctrl;

    // Copy of the write of the previous cycle, which the RAM read missed.
    logic                    r_byp_vld;
    logic [CW-1:0]           r_byp_idx;
    logic signed [ACC_W-1:0] r_byp_val;

    logic signed [ACC_W-1:0] ram_q;
    logic signed [ACC_W-1:0] operand;
    logic signed [ACC_W-1:0] pix_x;
    logic signed [SW-1:0]    sum;
    logic signed [SW-1:0]    sum_c;
    logic signed [ACC_W-1:0] n_acc;

    // A beat leaves the queue only when the result queue can take its result.
    assign o_job_pop = !i_job_empty &&
                       ((LW + 1)'(i_out_level) + (LW + 1)'(r_e_vld) < (LW + 1)'(OUT_DEPTH));

    wpms_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_WIDTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (r_e_vld),
        .i_waddr (r_e_idx),
        .i_wdata (n_acc),
        .i_raddr (i_idx),
        .o_rdata (ram_q)
    );

    // New accumulator value for the pixel in the execute stage.
    always_comb begin
        operand = (r_byp_vld && (r_byp_idx == r_e_idx)) ? r_byp_val : ram_q;
        pix_x   = ACC_W'(r_e_pix);
        sum     = SW'(operand) + SW'(pix_x);
        if (sum > SUM_MAX) begin
            sum_c = SUM_MAX;
        end else if (sum < SUM_MIN) begin
            sum_c = SUM_MIN;
        end else begin
            sum_c = sum;
        end
        if (r_e_ctrl.first) begin
            if ((i_pool_mode == POOL_MAX) && r_e_ctrl.padded && (pix_x < 0)) begin
                n_acc = '0;
            end else begin
                n_acc = pix_x;
            end
        end else if (i_pool_mode == POOL_MAX) begin
            n_acc = (pix_x > operand) ? pix_x : operand;
        end else begin
            n_acc = ACC_W'(sum_c);
        end
    end

    assign o_res_valid  = r_e_vld && r_e_ctrl.emit;
    assign o_res_pooled = n_acc[OUT_BITS-1:0];
    assign o_res_last   = r_e_ctrl.is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld   <= 1'b0;
            r_byp_vld <= 1'b0;
        end else begin
            r_e_vld   <= o_job_pop;
            r_byp_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_e_pix  <= i_pixel;
            r_e_idx  <= i_idx;
            r_e_ctrl <= i_ctrl;
        end
        r_byp_idx <= r_e_idx;
        r_byp_val <= n_acc;
    end

    // The result queue always has room for a result that is pushed.
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (i_out_level < LW'(OUT_DEPTH)))
        else $error("result pushed into a full queue");

    // A running maximum never falls.
    a_max_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_vld && !r_e_ctrl.first && (i_pool_mode == POOL_MAX)) |-> (n_acc >= operand))
        else $error("running maximum decreased");

endmodule

@@ hw/rtl/window_pooling_max_or_sum.sv @@
// A result on the result ports comes from the beat with the last real pixel of its window,
// which passes through the pixel queue and the execute stage into the result queue.
// Throughput: one pixel per cycle while the result queue has room, set by the single
// read-modify-write of the accumulator RAM per pixel, with a bypass of the previous cycle's write.
// Reset is synchronous and active low: it clears the raster position, both queues and
// the execute stage, and loads the register defaults; the accumulator RAM is not cleared.
module window_pooling_max_or_sum #(
    parameter int MAX_WIDTH  = wpms_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = wpms_pkg::MAX_WINDOW_DEF,
    parameter int PIXEL_BITS = wpms_pkg::PIXEL_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    input  logic signed [PIXEL_BITS-1:0]         i_pixel,
    output logic                                 full,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [wpms_pkg::OUT_BITS-1:0] o_pooled,
    output logic                                 o_last,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [wpms_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [wpms_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    import wpms_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int W1    = $clog2(MAX_WIDTH + 1);
    localparam int CTRLW = $bits(t_job_ctrl);
    localparam int MIDW  = PIXEL_BITS + CW + CTRLW;
    localparam int OUTW  = OUT_BITS + 1;

    logic [WS_BITS-1:0]     r_window_size;
    logic [IW_BITS-1:0]     r_image_width;
    logic [HEIGHT_BITS-1:0] r_image_height;
    t_pool_mode             r_pool_mode;

    logic                   cfg_we;
    logic [WW-1:0]          win_c;
    logic [W1-1:0]          wid_c;
    logic [HEIGHT_BITS-1:0] hgt_c;

    logic                         accept;
    logic                         f_valid;
    logic signed [PIXEL_BITS-1:0] f_pixel;
    logic [CW-1:0]                f_idx;
    t_job_ctrl                    f_ctrl;

    logic [MIDW-1:0]              mid_din, mid_dout;
    logic                         mid_full, mid_empty, mid_pop;
    logic signed [PIXEL_BITS-1:0] b_pixel;
    logic [CW-1:0]                b_idx;
    t_job_ctrl                    b_ctrl;

    logic                          res_valid;
    logic [OUT_BITS-1:0]           res_pooled;
    logic                          res_last;
    logic [OUTW-1:0]               out_dout;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_level;

    // Register file; any write restarts the image.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size  <= WS_BITS'(WINDOW_SIZE_RST);
            r_image_width  <= IW_BITS'(IMAGE_WIDTH_RST);
            r_image_height <= HEIGHT_BITS'(IMAGE_HEIGHT_RST);
            r_pool_mode    <= POOL_MAX;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW_SIZE:  r_window_size  <= i_cfg_data[WS_BITS-1:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[IW_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[HEIGHT_BITS-1:0];
                CFG_POOL_MODE:    r_pool_mode    <= t_pool_mode'(i_cfg_data[0]);
                default: ;
            endcase
        end
    end

    // Register values brought into their legal ranges.
    always_comb begin
        if (r_window_size == '0) begin
            win_c = WW'(1);
        end else if ({1'b0, r_window_size} > (WS_BITS + 1)'(MAX_WINDOW)) begin
            win_c = WW'(MAX_WINDOW);
        end else begin
            win_c = WW'(r_window_size);
        end

        if (r_image_width == '0) begin
            wid_c = W1'(1);
        end else if (HEIGHT_BITS'(r_image_width) > HEIGHT_BITS'(MAX_WIDTH)) begin
            wid_c = W1'(MAX_WIDTH);
        end else begin
            wid_c = W1'(r_image_width);
        end

        if (r_image_height == '0) begin
            hgt_c = HEIGHT_BITS'(1);
        end else if (r_image_height > HEIGHT_BITS'(MAX_HEIGHT)) begin
            hgt_c = HEIGHT_BITS'(MAX_HEIGHT);
        end else begin
            hgt_c = r_image_height;
        end
    end

    assign accept = push && !full;
    assign full   = mid_full;

    wpms_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_we),
        .i_win     (win_c),
        .i_width   (wid_c),
        .i_height  (hgt_c),
        .i_accept  (accept),
        .i_pixel   (i_pixel),
        .o_valid   (f_valid),
        .o_pixel   (f_pixel),
        .o_idx     (f_idx),
        .o_ctrl    (f_ctrl)
    );

    // Pixel queue between the front and the back part.
    assign mid_din = {f_pixel, f_idx, f_ctrl};

    wpms_queue #(
        .WIDTH (MIDW),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (mid_din),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_dout),
        .o_empty (mid_empty),
        .o_level ()
    );

    assign b_pixel = mid_dout[MIDW-1 -: PIXEL_BITS];
    assign b_idx   = mid_dout[CTRLW +: CW];
    assign b_ctrl  = t_job_ctrl'(mid_dout[CTRLW-1:0]);

    wpms_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .OUT_DEPTH  (OUT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pool_mode  (r_pool_mode),
        .i_job_empty  (mid_empty),
        .o_job_pop    (mid_pop),
        .i_pixel      (b_pixel),
        .i_idx        (b_idx),
        .i_ctrl       (b_ctrl),
        .i_out_level  (out_level),
        .o_res_valid  (res_valid),
        .o_res_pooled (res_pooled),
        .o_res_last   (res_last)
    );

    // Result queue towards the consumer.
    wpms_queue #(
        .WIDTH (OUTW),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  ({res_last, res_pooled}),
        .o_full  (),
        .i_pop   (pop),
        .o_data  (out_dout),
        .o_empty (empty),
        .o_level (out_level)
    );

    assign o_pooled = out_dout[OUT_BITS-1:0];
    assign o_last   = out_dout[OUT_BITS];

endmodule

@@ sim/pool_checker.sv @@
module pool_checker #(
    parameter int MAX_WIDTH  = wpms_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = wpms_pkg::MAX_WINDOW_DEF,
    parameter int PIXEL_BITS = wpms_pkg::PIXEL_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic                                  i_full,
    input  logic signed [PIXEL_BITS-1:0]          i_pixel,
    input  logic                                  i_empty,
    input  logic                                  i_pop,
    input  logic signed [wpms_pkg::OUT_BITS-1:0]  i_pooled,
    input  logic                                  i_last,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [wpms_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [wpms_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_pixels,
    output int                                    o_windows,
    output int                                    o_images
);

    import wpms_pkg::*;

    localparam longint SUM_MIN = -(longint'(1) << (OUT_BITS - 1));
    localparam longint SUM_MAX = (longint'(1) << (OUT_BITS - 1)) - 1;

    typedef struct {
        logic signed [OUT_BITS-1:0] pooled;
        logic                       last;
    } t_window_result;

    // Copy of the register file and of the raster position.
    logic [WS_BITS-1:0]         win_reg;
    logic [IW_BITS-1:0]         width_reg;
    logic [HEIGHT_BITS-1:0]     height_reg;
    t_pool_mode                 mode_reg;
    logic signed [OUT_BITS-1:0] col_acc [MAX_WIDTH];
    int unsigned                col_at, row_at, col_ph, row_ph;

    // Windows that have completed but whose beat has not yet been popped.
    t_window_result             window_q [$];
    int                         fail_count;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic restart_image();
        col_at = 0;
        row_at = 0;
        col_ph = 0;
        row_ph = 0;
    endtask

    // Folds one pixel into its column's window and queues the window result when
    // this pixel is the last real one of that window.
    task automatic fold_pixel(input logic signed [PIXEL_BITS-1:0] px);
        int unsigned    w, wd, ht, c, r, c0, r0, idx, last_c, last_r;
        logic           padded;
        longint         pv, total;
        t_window_result res;
        w  = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg);
        wd = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        ht = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
        pv = px;
        if (col_at >= wd || row_at >= ht || col_ph >= w || row_ph >= w) begin
            restart_image();
        end
        c      = col_at;
        r      = row_at;
        c0     = c - col_ph;
        r0     = r - row_ph;
        idx    = c / w;
        if (idx >= MAX_WIDTH) begin
            idx = MAX_WIDTH - 1;
        end
        padded = (c0 + w > wd) || (r0 + w > ht);

        // The first pixel opens the window; padded zeros win over negatives in max mode.
        if (col_ph == 0 && row_ph == 0) begin
            if (mode_reg == POOL_MAX && padded && pv < 0) begin
                col_acc[idx] = '0;
            end else begin
                col_acc[idx] = OUT_BITS'(pv);
            end
        end else if (mode_reg == POOL_MAX) begin
            if (pv > col_acc[idx]) begin
                col_acc[idx] = OUT_BITS'(pv);
            end
        end else begin
            total = longint'(col_acc[idx]) + pv;
            if (total > SUM_MAX) begin
                total = SUM_MAX;
            end
            if (total < SUM_MIN) begin
                total = SUM_MIN;
            end
            col_acc[idx] = OUT_BITS'(total);
        end

        last_c = (c0 + w > wd) ? wd - 1 : c0 + w - 1;
        last_r = (r0 + w > ht) ? ht - 1 : r0 + w - 1;
        if (c == last_c && r == last_r) begin
            res.pooled = col_acc[idx];
            res.last   = (c == wd - 1) && (r == ht - 1);
            window_q.insert(window_q.size(), res);
            if (res.last) begin
                o_images++;
            end
        end

        // Step to the next raster position.
        if (c + 1 >= wd) begin
            col_at = 0;
            col_ph = 0;
            if (r + 1 >= ht) begin
                row_at = 0;
                row_ph = 0;
            end else begin
                row_at = r + 1;
                row_ph = (row_ph + 1 >= w) ? 0 : row_ph + 1;
            end
        end else begin
            col_at = c + 1;
            col_ph = (col_ph + 1 >= w) ? 0 : col_ph + 1;
        end
    endtask

    // Watch all three channels at every rising edge.
    always @(posedge i_clk) begin : watch
        t_window_result exp_win;
        if (!i_rst_n) begin
            win_reg    = WS_BITS'(WINDOW_SIZE_RST);
            width_reg  = IW_BITS'(IMAGE_WIDTH_RST);
            height_reg = HEIGHT_BITS'(IMAGE_HEIGHT_RST);
            mode_reg   = POOL_MAX;
            for (int k = 0; k < MAX_WIDTH; k++) begin
                col_acc[k] = '0;
            end
            restart_image();
            window_q.delete();
        end else begin
            // Compare a popped result beat with the oldest completed window.
            if (i_pop && !i_empty) begin
                if (window_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d last %0b with no window pending",
                                              i_pooled, i_last));
                end else begin
                    exp_win = window_q.pop_front();
                    if (i_pooled !== exp_win.pooled) begin
                        report_mismatch($sformatf("pooled %0d, expected %0d",
                                                  i_pooled, exp_win.pooled));
                    end
                    if (i_last !== exp_win.last) begin
                        report_mismatch($sformatf("last %b, expected %b (pooled %0d)",
                                                  i_last, exp_win.last, exp_win.pooled));
                    end
                    o_windows++;
                end
            end

            // Any register write, known index or not, restarts the image.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WINDOW_SIZE:  win_reg    = i_cfg_data[WS_BITS-1:0];
                    CFG_IMAGE_WIDTH:  width_reg  = i_cfg_data[IW_BITS-1:0];
                    CFG_IMAGE_HEIGHT: height_reg = i_cfg_data[HEIGHT_BITS-1:0];
                    CFG_POOL_MODE:    mode_reg   = t_pool_mode'(i_cfg_data[0]);
                    default: ;
                endcase
                restart_image();
            end

            if (i_push && !i_full) begin
                fold_pixel(i_pixel);
                o_pixels++;
            end
        end
        o_pending <= window_q.size();
    end

    initial begin
        fail_count = 0;
        o_pending  = 0;
        o_pixels   = 0;
        o_windows  = 0;
        o_images   = 0;
    end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
    import wpms_pkg::*;

    localparam int PB           = PIXEL_BITS_DEF;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEMS_EACH   = 550;
    localparam int UNKNOWN_LO   = CFG_POOL_MODE + 1;
    localparam int UNKNOWN_HI   = (1 << CFG_IDX_BITS) - 1;
    localparam logic signed [PB-1:0] PX_MAX = {1'b0, {(PB - 1){1'b1}}};
    localparam logic signed [PB-1:0] PX_MIN = {1'b1, {(PB - 1){1'b0}}};

    // Three by three image with two by two windows: every window but the first is padded,
    // and negatives open the padded ones.
    localparam logic signed [PB-1:0] EDGE_IMAGE [9] = '{
        PX_MIN, -1, -5,
        -300, -2, PX_MIN,
        -1, PX_MAX, -7
    };

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        push        = 1'b0;
    logic signed [PB-1:0]        i_pixel     = '0;
    logic                        pop         = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]    i_cfg_data  = '0;
    logic                        full, empty, o_last, o_cfg_ready;
    logic signed [OUT_BITS-1:0]  o_pooled;

    int fail_count, results_pending, pixels_seen, windows_seen, images_seen;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cfg_writes  = 0;

    window_pooling_max_or_sum u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_pixel     (i_pixel),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_pooled    (o_pooled),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pool_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_pixel      (i_pixel),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_pooled     (o_pooled),
        .i_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (results_pending),
        .o_pixels     (pixels_seen),
        .o_windows    (windows_seen),
        .o_images     (images_seen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random with the current percentage.
    always @(negedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Offers one pixel beat, with random idle cycles ahead of it, and holds it until taken.
    task automatic send_pixel(input logic signed [PB-1:0] px);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (full);
    endtask

    task automatic write_reg(input int idx, input int data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_IDX_BITS'(idx);
        i_cfg_data  <= CFG_DATA_BITS'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Stops pushing, waits for every pending window and lets the pipeline settle.
    task automatic wait_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (results_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned          wd, ht, area, n_img, n_part, sent, pick;
        logic [CFG_DATA_BITS-1:0] d;
        logic signed [PB-1:0] px, flat_px;
        logic                 flat;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: padded edges in max mode.
        write_reg(CFG_WINDOW_SIZE, 2);
        write_reg(CFG_IMAGE_WIDTH, 3);
        write_reg(CFG_IMAGE_HEIGHT, 3);
        write_reg(CFG_POOL_MODE, POOL_MAX);
        foreach (EDGE_IMAGE[k]) begin
            send_pixel(EDGE_IMAGE[k]);
        end
        wait_idle();

        // Directed: the largest possible window sum.
        write_reg(CFG_WINDOW_SIZE, 4);
        write_reg(CFG_IMAGE_WIDTH, 4);
        write_reg(CFG_IMAGE_HEIGHT, 4);
        write_reg(CFG_POOL_MODE, POOL_SUM);
        repeat (16) send_pixel(PX_MAX);
        wait_idle();

        // Random phases under the three idle patterns.
        for (int m = 0; m < 3; m++) begin
            tx_idle_pct = (m == 0) ? 9 : ((m == 1) ? 54 : 0);
            rx_idle_pct = (m == 0) ? 54 : ((m == 1) ? 9 : 0);
            sent = 0;
            while (sent < ITEMS_EACH) begin
                if ($urandom_range(0, 5) == 0) begin
                    write_reg($urandom_range(UNKNOWN_LO, UNKNOWN_HI),
                              CFG_DATA_BITS'($urandom));
                end

                // Window size, with zero and oversize values now and then.
                pick = $urandom_range(0, 9);
                d = CFG_DATA_BITS'($urandom);
                d[WS_BITS-1:0] = WS_BITS'((pick == 0) ? 0 :
                                 ((pick == 1) ? $urandom_range(MAX_WINDOW_DEF + 1, 7)
                                              : $urandom_range(1, MAX_WINDOW_DEF)));
                write_reg(CFG_WINDOW_SIZE, d);

                pick = $urandom_range(0, 19);
                wd = (pick == 0) ? 0 :
                     ((pick == 1) ? $urandom_range(MAX_WIDTH_DEF + 1, 127) :
                     ((pick < 4) ? MAX_WIDTH_DEF : $urandom_range(1, 24)));
                d = CFG_DATA_BITS'($urandom);
                d[IW_BITS-1:0] = IW_BITS'(wd);
                write_reg(CFG_IMAGE_WIDTH, d);

                pick = $urandom_range(0, 19);
                ht = (pick == 0) ? 0 :
                     ((pick == 1) ? $urandom_range(MAX_HEIGHT + 1, 8191) :
                     ((pick == 2) ? $urandom_range(100, MAX_HEIGHT) : $urandom_range(1, 8)));
                write_reg(CFG_IMAGE_HEIGHT, ht);

                d = CFG_DATA_BITS'($urandom);
                d[0] = $urandom_range(0, 1);
                write_reg(CFG_POOL_MODE, d);

                // Mostly whole images, sometimes cut short or only a fragment.
                wd   = (wd == 0) ? 1 : ((wd > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : wd);
                ht   = (ht == 0) ? 1 : ((ht > MAX_HEIGHT) ? MAX_HEIGHT : ht);
                area = wd * ht;
                if (area <= 300) begin
                    n_img  = ($urandom_range(0, 4) == 0) ? 0 :
                             $urandom_range(1, (300 / area > 3) ? 3 : 300 / area);
                    n_part = (area > 1 && $urandom_range(0, 3) == 0) ?
                             $urandom_range(1, area - 1) : 0;
                end else begin
                    n_img  = 0;
                    n_part = $urandom_range(20, 200);
                end
                flat    = ($urandom_range(0, 9) == 0);
                flat_px = $urandom_range(0, 1) ? PX_MAX : PX_MIN;

                for (int k = 0; k < n_img * area + n_part; k++) begin
                    pick = $urandom_range(0, 9);
                    if (flat) begin
                        px = flat_px;
                    end else if (pick == 0) begin
                        px = PX_MAX;
                    end else if (pick == 1) begin
                        px = PX_MIN;
                    end else if (pick == 2) begin
                        px = PB'($urandom_range(0, 16) - 8);
                    end else begin
                        px = PB'($urandom);
                    end
                    send_pixel(px);
                    sent++;
                end
                wait_idle();
            end
        end

        $display("Pushed %0d pixels, checked %0d pooled windows over %0d whole images.",
                 pixels_seen, windows_seen, images_seen);
        $display("Made %0d register writes across max and sum modes and clamped sizes.",
                 cfg_writes);
        if (fail_count == 0 && results_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #3000000;
        $display("Timeout: the run did not complete.");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
